// ===== rtl/lmfc_pkg.sv =====
// shared types, constants and font table for the led matrix frame composer
package lmfc_pkg;

  localparam int unsigned ROWS      = 8;
  localparam int unsigned ROW_W     = $clog2(ROWS);
  localparam int unsigned DIGIT_MAX = 99;
  localparam int unsigned QUEUE_DEPTH = 2;

  // reciprocal of ten in 11 fractional bits, exact for values up to 99
  localparam logic [7:0]  TENTH_RECIP = 8'd205;
  localparam int unsigned TENTH_SHIFT = 11;

  localparam logic MODE_DIGITS = 1'b0;
  localparam logic MODE_BAR    = 1'b1;

  localparam logic [2:0] ROT_0   = 3'd0;
  localparam logic [2:0] ROT_90  = 3'd1;
  localparam logic [2:0] ROT_180 = 3'd2;
  localparam logic [2:0] ROT_270 = 3'd3;

  // request word
  typedef struct packed {
    logic        mode;
    logic [9:0]  digit_value;
    logic [2:0]  rotation;
    logic [11:0] sample_col0;
    logic [11:0] sample_col1;
    logic [11:0] sample_col2;
    logic [11:0] sample_col3;
    logic [11:0] sample_col4;
    logic [11:0] sample_col5;
    logic [11:0] sample_col6;
    logic [11:0] sample_col7;
  } request_t;

  // row write word
  typedef struct packed {
    logic [3:0] row_address;
    logic [7:0] row_data;
    logic       last_row;
  } result_t;

  // unrotated frame, row index outer
  typedef logic [ROWS-1:0][7:0] frame_t;

  // composed frame waiting for the back end
  typedef struct packed {
    frame_t     frame;
    logic [2:0] rotation;
  } job_t;

  // queue status seen by the back end
  typedef struct packed {
    logic not_empty;
    job_t head;
  } queue_head_t;

  // eight glyph rows of one digit, row 0 in the low nibble
  function automatic logic [31:0] glyph_rows(input logic [3:0] digit);
    logic [31:0] rows;
    case (digit)
      4'd0:    rows = 32'h0EAAAAE0;
      4'd1:    rows = 32'h04644440;
      4'd2:    rows = 32'h04A842E0;
      4'd3:    rows = 32'h0E848A60;
      4'd4:    rows = 32'h0AAE8880;
      4'd5:    rows = 32'h0E268A60;
      4'd6:    rows = 32'h0E2EAAE0;
      4'd7:    rows = 32'h0E842220;
      4'd8:    rows = 32'h0EAEAAE0;
      4'd9:    rows = 32'h0EAE8AE0;
      default: rows = 32'h00000000;
    endcase
    return rows;
  endfunction

endpackage

// ===== rtl/led_matrix_frame_composer_unit.sv =====
// top level of the led matrix frame composer
// Each accepted request (start high while busy is low) produces eight row writes,
// rows 1 to 8 in order, each shown for one cycle with strobe high and the eighth
// marked by last_row; the writes of one request come in consecutive cycles.
// From idle, a request passes the front register, a queue entry, the back end's
// job register and the output register before its first row write appears. The
// back end's row counter, which issues one row write per cycle, sets the sustained
// request rate. A two-entry frame queue and a one-word front register let up to
// three further requests be taken while a frame is being written out; busy rises
// only when all of them are occupied. The receiver cannot stall the row writes.
module led_matrix_frame_composer_unit
  import lmfc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  request_t request,
  output logic     strobe,
  output result_t  result
);

  logic        queue_full;
  logic        push;
  job_t        push_job;
  logic        pop;
  queue_head_t head;

  lmfc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .request    (request),
    .queue_full (queue_full),
    .push       (push),
    .push_job   (push_job)
  );

  lmfc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .full     (queue_full),
    .head     (head)
  );

  lmfc_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .pop    (pop),
    .strobe (strobe),
    .result (result)
  );

  // last row flag only on row eight
  assert property (@(posedge clk) disable iff (rst)
    strobe |-> (result.last_row == (result.row_address == 4'd8)))
    else $error("last_row does not match row eight");

  // rows of one frame follow without a gap
  assert property (@(posedge clk) disable iff (rst)
    strobe && !result.last_row |=> strobe)
    else $error("gap inside a frame");

  // row addresses step by one within a frame
  assert property (@(posedge clk) disable iff (rst)
    strobe && !result.last_row |=> result.row_address == $past(result.row_address) + 4'd1)
    else $error("row address out of sequence");

  // a frame begins at row one
  assert property (@(posedge clk) disable iff (rst)
    strobe && result.last_row |=> !strobe || result.row_address == 4'd1)
    else $error("frame does not start at row one");

endmodule

// ===== rtl/lmfc_front.sv =====
// front end: takes requests, draws the unrotated frame and pushes it to the queue
module lmfc_front
  import lmfc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  request_t request,
  input  logic     queue_full,
  output logic     push,
  output job_t     push_job
);

  logic     valid;
  logic     valid_next;
  request_t word;

  logic [6:0]  num_sat;
  logic [14:0] tens_prod;
  logic [3:0]  tens;
  logic [3:0]  ones;
  logic [6:0]  tens_times_ten;
  logic [31:0] ones_rows;
  logic [31:0] tens_rows;
  logic [ROWS-1:0][11:0] samples;
  frame_t      digit_frame;
  frame_t      bar_frame;

  assign busy = valid & queue_full;
  assign push = valid & ~queue_full;

  // holding register for one accepted word
  always_comb begin
    valid_next = valid;
    if (start && !busy) begin
      valid_next = 1'b1;
    end else if (push) begin
      valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      word <= request;
    end
  end

  // split the saturated number into tens and ones
  always_comb begin
    num_sat        = (word.digit_value > 10'(DIGIT_MAX)) ? 7'(DIGIT_MAX)
                                                          : word.digit_value[6:0];
    tens_prod      = 15'(num_sat) * 15'(TENTH_RECIP);
    tens           = tens_prod[TENTH_SHIFT +: 4];
    tens_times_ten = 7'(tens) * 7'd10;
    ones           = 4'(num_sat - tens_times_ten);
    ones_rows      = glyph_rows(ones);
    tens_rows      = glyph_rows(tens);
    for (int r = 0; r < ROWS; r++) begin
      digit_frame[r] = {ones_rows[4*r +: 4], tens_rows[4*r +: 4]};
    end
  end

  // bar graph: column k lit in row r when the sample exceeds r steps
  always_comb begin
    samples = {word.sample_col7, word.sample_col6, word.sample_col5, word.sample_col4,
               word.sample_col3, word.sample_col2, word.sample_col1, word.sample_col0};
    for (int r = 0; r < ROWS; r++) begin
      for (int k = 0; k < ROWS; k++) begin
        bar_frame[r][k] = samples[k] > {1'b0, 3'(r), 8'h00};
      end
    end
  end

  assign push_job.frame    = (word.mode == MODE_BAR) ? bar_frame : digit_frame;
  assign push_job.rotation = word.rotation;

endmodule

// ===== rtl/lmfc_queue.sv =====
// two-entry queue of composed frames between front and back ends
module lmfc_queue
  import lmfc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  job_t        push_job,
  input  logic        pop,
  output logic        full,
  output queue_head_t head
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);

  job_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;

  assign full           = count == (PTR_W+1)'(QUEUE_DEPTH);
  assign head.not_empty = count != '0;
  assign head.head      = entries[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
    end
  end

endmodule

// ===== rtl/lmfc_back.sv =====
// back end: rotates the current frame one row per cycle and issues row writes
module lmfc_back
  import lmfc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  queue_head_t head,
  output logic        pop,
  output logic        strobe,
  output result_t     result
);

  logic             active;
  logic [ROW_W-1:0] row;
  job_t             job;
  logic             last;
  logic [7:0]       row_bits;

  assign last = row == ROW_W'(ROWS - 1);
  assign pop  = head.not_empty & (~active | last);

  // row sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      row    <= '0;
    end else if (pop) begin
      active <= 1'b1;
      row    <= '0;
    end else if (active) begin
      active <= ~last;
      row    <= row + ROW_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job <= head.head;
    end
  end

  // rotated row for the current row index
  always_comb begin
    row_bits = '0;
    for (int j = 0; j < ROWS; j++) begin
      unique case (job.rotation)
        ROT_0:   row_bits[j]     = job.frame[row][j];
        ROT_90:  row_bits[j]     = job.frame[j][ROW_W'(ROWS - 1) - row];
        ROT_180: row_bits[7 - j] = job.frame[ROW_W'(ROWS - 1) - row][j];
        ROT_270: row_bits[7 - j] = job.frame[j][row];
        default: row_bits[j]     = 1'b0;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= active;
    end
  end

  always_ff @(posedge clk) begin
    result.row_address <= 4'(row) + 4'd1;
    result.row_data    <= row_bits;
    result.last_row    <= last;
  end

endmodule

// ===== verif/testbench.sv =====
// self-checking testbench for the led matrix frame composer: predicted row writes vs. dut
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import lmfc_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES   = 16;
  localparam int unsigned RANDOM_WORDS   = 108;
  localparam int unsigned REPORT_LIMIT   = 10;

  // digit font, row 0 first within each digit
  localparam logic [0:9][0:7][7:0] FONT = {
    64'h000E0A0A0A0A0E00, 64'h0004040404060400, 64'h000E0204080A0400,
    64'h00060A0804080E00, 64'h000808080E0A0A00, 64'h00060A0806020E00,
    64'h000E0A0A0E020E00, 64'h0002020204080E00, 64'h000E0A0A0E0A0E00,
    64'h000E0A080E0A0E00
  };

  // column levels sitting on and just past the row thresholds
  localparam logic [95:0] EDGE_LEVELS = {12'd0, 12'd1, 12'd256, 12'd257,
                                         12'd512, 12'd1792, 12'd1793, 12'd2048};
  localparam logic [95:0] BELOW_LEVELS = {12'd255, 12'd511, 12'd767, 12'd1023,
                                          12'd1279, 12'd1535, 12'd1791, 12'd2047};

  // predicts the eight row writes of each request and checks them in order
  class frame_row_checker;
    result_t     expected_rows[$];
    int unsigned mismatches;
    int unsigned rows_checked;

    function new();
      mismatches   = 0;
      rows_checked = 0;
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) $display("%s", msg);
    endfunction

    function void note_request(request_t req);
      logic [7:0]  frame [8];
      logic [11:0] level [8];
      logic [7:0]  turned;
      result_t     row;
      int unsigned num;
      int unsigned ones;
      int unsigned tens;
      int          i;
      int          j;
      level = '{req.sample_col0, req.sample_col1, req.sample_col2, req.sample_col3,
                req.sample_col4, req.sample_col5, req.sample_col6, req.sample_col7};
      // unrotated frame
      if (req.mode == MODE_DIGITS) begin
        num  = (req.digit_value > DIGIT_MAX) ? DIGIT_MAX : req.digit_value;
        ones = num % 10;
        tens = num / 10;
        for (i = 0; i < 8; i++) frame[i] = {FONT[ones][i][3:0], FONT[tens][i][3:0]};
      end else begin
        for (i = 0; i < 8; i++)
          for (j = 0; j < 8; j++) frame[i][j] = (int'(level[j]) > i * 256);
      end
      // rotation, unused angle codes blank the frame
      for (i = 0; i < 8; i++) begin
        turned = '0;
        for (j = 0; j < 8; j++) begin
          case (req.rotation)
            ROT_0:   turned[j]     = frame[i][j];
            ROT_90:  turned[j]     = frame[j][7 - i];
            ROT_180: turned[7 - j] = frame[7 - i][j];
            ROT_270: turned[7 - j] = frame[j][i];
            default: turned[j]     = 1'b0;
          endcase
        end
        row.row_address = 4'(i + 1);
        row.row_data    = turned;
        row.last_row    = (i == 7);
        expected_rows.push_back(row);
      end
    endfunction

    function void check_row(result_t got);
      result_t want;
      if (expected_rows.size() == 0) begin
        flag($sformatf("unexpected row write: addr %0d data %02h last %0b",
                       got.row_address, got.row_data, got.last_row));
        return;
      end
      want = expected_rows.pop_front();
      rows_checked++;
      if (got.row_address !== want.row_address || got.row_data !== want.row_data ||
          got.last_row !== want.last_row)
        flag($sformatf({"row write mismatch: expected addr %0d data %02h last %0b,",
                        " got addr %0d data %02h last %0b"},
                       want.row_address, want.row_data, want.last_row,
                       got.row_address, got.row_data, got.last_row));
    endfunction
  endclass

  logic     clk;
  logic     rst = 1'b1;
  logic     start = 1'b0;
  request_t request = '0;
  logic     busy;
  logic     strobe;
  result_t  result;

  frame_row_checker rows_chk = new();

  int unsigned idle_cycles = 0;
  int unsigned n_digits = 0;
  int unsigned n_bar = 0;
  int unsigned n_blank = 0;
  int unsigned burst_left = 0;

  led_matrix_frame_composer_unit u_dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .strobe  (strobe),
    .result  (result)
  );

  // 2 ns clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // monitor: accepted request words and row writes
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        rows_chk.note_request(request);
        if (request.mode == MODE_DIGITS) n_digits++;
        else n_bar++;
        if (request.rotation > ROT_270) n_blank++;
      end
      if (strobe) rows_chk.check_row(result);
      if ((start && !busy) || strobe) idle_cycles = 0;
      else idle_cycles++;
    end
  end

  // watchdog on cycles without any accepted word or row write
  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  function automatic request_t make_request(logic mode, logic [9:0] value,
                                            logic [2:0] rot, logic [95:0] levels);
    return request_t'({mode, value, rot, levels});
  endfunction

  // levels favor the row thresholds and the extremes
  function automatic logic [11:0] random_level();
    int unsigned pick;
    int unsigned step;
    pick = $urandom_range(0, 9);
    step = $urandom_range(0, 7);
    if (pick < 4) return 12'($urandom);
    if (pick < 8) return 12'(step * 256 + 1) - 12'($urandom_range(0, 2));
    return ($urandom_range(0, 1) != 0) ? 12'hFFF : 12'h000;
  endfunction

  function automatic request_t random_request();
    logic [9:0]  value;
    logic [2:0]  rot;
    logic [95:0] levels;
    int unsigned pick;
    int          k;
    pick = $urandom_range(0, 9);
    if (pick < 6) value = 10'($urandom_range(0, 99));
    else if (pick < 8) value = 10'($urandom_range(100, 1023));
    else value = 10'($urandom);
    rot = ($urandom_range(0, 7) != 0) ? 3'($urandom_range(0, 3)) : 3'($urandom_range(4, 7));
    for (k = 0; k < 8; k++) levels[k*12 +: 12] = random_level();
    return make_request(1'($urandom_range(0, 1)), value, rot, levels);
  endfunction

  // hold one request word until the block takes it
  task automatic send_request(input request_t req);
    start   <= 1'b1;
    request <= req;
    do @(posedge clk); while (busy);
  endtask

  // bursts of random length separated by random gaps
  task automatic send_paced(input request_t req);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 13);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    send_request(req);
  endtask

  // wait with no new request until every expected row write has come
  task automatic drain_rows();
    start <= 1'b0;
    do @(posedge clk); while (rows_chk.expected_rows.size() != 0);
  endtask

  initial begin
    int unsigned n;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: digit extremes, saturation, every digit, every angle
    send_paced(make_request(MODE_DIGITS, 10'd0, ROT_0, '0));
    send_paced(make_request(MODE_DIGITS, 10'd99, ROT_0, '0));
    send_paced(make_request(MODE_DIGITS, 10'd100, ROT_0, '0));
    send_paced(make_request(MODE_DIGITS, 10'd1023, ROT_90, '1));
    send_paced(make_request(MODE_DIGITS, 10'd12, ROT_90, '1));
    send_paced(make_request(MODE_DIGITS, 10'd34, ROT_180, EDGE_LEVELS));
    send_paced(make_request(MODE_DIGITS, 10'd56, ROT_270, '0));
    send_paced(make_request(MODE_DIGITS, 10'd78, ROT_0, BELOW_LEVELS));
    send_paced(make_request(MODE_DIGITS, 10'd23, ROT_270, '1));
    send_paced(make_request(MODE_DIGITS, 10'd81, ROT_180, '0));
    send_paced(make_request(MODE_DIGITS, 10'd90, 3'd4, '0));
    send_paced(make_request(MODE_DIGITS, 10'd45, 3'd7, '1));
    // directed: bar graph thresholds and extremes
    send_paced(make_request(MODE_BAR, 10'd1023, ROT_0, '0));
    send_paced(make_request(MODE_BAR, 10'd0, ROT_0, '1));
    send_paced(make_request(MODE_BAR, 10'd0, ROT_0, EDGE_LEVELS));
    send_paced(make_request(MODE_BAR, 10'd0, ROT_90, EDGE_LEVELS));
    send_paced(make_request(MODE_BAR, 10'd0, ROT_180, EDGE_LEVELS));
    send_paced(make_request(MODE_BAR, 10'd0, ROT_270, EDGE_LEVELS));
    send_paced(make_request(MODE_BAR, 10'd1023, ROT_0, BELOW_LEVELS));
    send_paced(make_request(MODE_BAR, 10'd0, ROT_90, BELOW_LEVELS));
    send_paced(make_request(MODE_BAR, 10'd0, 3'd5, '1));
    send_paced(make_request(MODE_BAR, 10'd0, 3'd6, EDGE_LEVELS));
    drain_rows();

    // random words, with one full drain in the middle
    for (n = 0; n < RANDOM_WORDS; n++) begin
      if (n == RANDOM_WORDS / 2) drain_rows();
      send_paced(random_request());
    end

    drain_rows();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (rows_chk.expected_rows.size() != 0)
      rows_chk.flag($sformatf("%0d expected row writes never came",
                              rows_chk.expected_rows.size()));

    $display("run covered %0d requests: %0d digit frames, %0d bar frames, %0d blanked",
             n_digits + n_bar, n_digits, n_bar, n_blank);
    $display("%0d row writes checked, %0d mismatches", rows_chk.rows_checked,
             rows_chk.mismatches);
    if (rows_chk.mismatches == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== led_matrix_frame_composer_unit.f =====
rtl/lmfc_pkg.sv
rtl/lmfc_front.sv
rtl/lmfc_queue.sv
rtl/lmfc_back.sv
rtl/led_matrix_frame_composer_unit.sv
verif/testbench.sv
